@@ rtl/ctrb_pkg.sv @@
// Shared constants and codes of the chunked transmit ring buffer.
`default_nettype none

package ctrb_pkg;

    localparam int CAPACITY_DEF      = 128;
    localparam int PACKAGE_BYTES_DEF = 8;

    localparam int DATA_W = 8;
    localparam int SIZE_W = 8;
    localparam int PLEN_W = 4;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_DONE = 1'b1;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_PKG    = 1'b1;

endpackage

`default_nettype wire

@@ rtl/ctrb_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
`default_nettype none

module ctrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/chunked_transmit_ring_buffer.sv @@
// Top level of the chunked transmit ring buffer: admission control and package drain.
//
// Input channel (in_valid/in_ready) carries one item: a message byte (action 0,
// with message_size read on a message's first byte) or a link-done notice (action 1).
// Output channel (out_valid/out_ready) carries results: an admission status
// (result_kind 0) on each message's first byte, and package bytes (result_kind 1)
// of up to PACKAGE_BYTES bytes, last_in_package marking the final one.
// One item is handled at a time; in_ready is high only while no result is pending.
// An item with no result leaves in_ready high. A status result appears in the cycle
// after acceptance. Each package byte is first read from the byte store, which has a
// registered read, and then presented, where it holds through any stall.
// When the receiver stalls, the current result holds and no new item is taken.
// Reset empties the buffer, clears pointers and counts and marks the link idle.
// The byte store needs no clearing pass; only written entries are ever read.
`default_nettype none

module chunked_transmit_ring_buffer #(
    parameter int CAPACITY      = ctrb_pkg::CAPACITY_DEF,
    parameter int PACKAGE_BYTES = ctrb_pkg::PACKAGE_BYTES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output      logic                        in_ready,
    input  wire logic                        action,
    input  wire logic [ctrb_pkg::DATA_W-1:0] data_byte,
    input  wire logic [ctrb_pkg::SIZE_W-1:0] message_size,
    output      logic                        out_valid,
    input  wire logic                        out_ready,
    output      logic                        result_kind,
    output      logic                        admitted,
    output      logic [ctrb_pkg::DATA_W-1:0] out_byte,
    output      logic                        last_in_package,
    output      logic [ctrb_pkg::PLEN_W-1:0] package_length
);

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = ((CNT_W > ctrb_pkg::SIZE_W) ? CNT_W : ctrb_pkg::SIZE_W) + 1;
    localparam int PKG_W = $clog2(PACKAGE_BYTES + 1);
    localparam int MX_W  = (CNT_W > PKG_W) ? CNT_W : PKG_W;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [SUM_W-1:0] CAP_SUM  = SUM_W'(CAPACITY);
    localparam logic [MX_W-1:0]  PB_MX    = MX_W'(PACKAGE_BYTES);
    localparam logic [PKG_W-1:0] PB_PKG   = PKG_W'(PACKAGE_BYTES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_STAT = 2'd1;
    localparam logic [1:0] ST_RD   = 2'd2;
    localparam logic [1:0] ST_BYTE = 2'd3;

    logic [1:0]                   state_reg,    state_next;
    logic [PTR_W-1:0]             rd_ptr_reg,   rd_ptr_next;
    logic [PTR_W-1:0]             wr_ptr_reg,   wr_ptr_next;
    logic [CNT_W-1:0]             count_reg,    count_next;
    logic                         idle_reg,     idle_next;
    logic [ctrb_pkg::SIZE_W-1:0]  left_reg,     left_next;
    logic                         acc_reg,      acc_next;
    logic [PKG_W-1:0]             pkg_left_reg, pkg_left_next;
    logic [PKG_W-1:0]             pkg_n_reg,    pkg_n_next;
    logic                         adm_reg,      adm_next;
    logic                         pkg_go_reg,   pkg_go_next;

    logic                         accept;
    logic                         first;
    logic                         fits;
    logic                         acc_eff;
    logic                         wr_en;
    logic [ctrb_pkg::SIZE_W-1:0]  left_dec;
    logic [CNT_W-1:0]             count_w;
    logic [CNT_W-1:0]             pkg_src;
    logic [PKG_W-1:0]             take;
    logic                         pkg_start;
    logic                         rd_en;
    logic                         out_fire;
    logic [ctrb_pkg::DATA_W-1:0]  ram_rdata;

    assign accept   = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;
    assign first    = (left_reg == '0);
    assign fits     = (SUM_W'(count_reg) + SUM_W'(message_size)) <= CAP_SUM;
    assign acc_eff  = first ? fits : acc_reg;
    assign wr_en    = accept && (action == ctrb_pkg::ACT_BYTE)
                      && !(first && (message_size == '0))
                      && acc_eff && (count_reg < CAP_CNT);
    assign left_dec = (first ? message_size : left_reg) - ctrb_pkg::SIZE_W'(1);
    assign count_w  = count_reg + CNT_W'(wr_en);
    assign pkg_src  = (action == ctrb_pkg::ACT_DONE) ? count_reg : count_w;
    assign take     = (MX_W'(pkg_src) > PB_MX) ? PB_PKG : PKG_W'(pkg_src);
    assign rd_en    = (state_reg == ST_RD);

    always_comb
    begin
        state_next    = state_reg;
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        count_next    = count_reg;
        idle_next     = idle_reg;
        left_next     = left_reg;
        acc_next      = acc_reg;
        pkg_left_next = pkg_left_reg;
        pkg_n_next    = pkg_n_reg;
        adm_next      = adm_reg;
        pkg_go_next   = pkg_go_reg;
        pkg_start     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (action == ctrb_pkg::ACT_DONE)
                    begin
                        if (!idle_reg)
                        begin
                            if (count_reg == '0)
                            begin
                                idle_next = 1'b1;
                            end
                            else
                            begin
                                pkg_start  = 1'b1;
                                state_next = ST_RD;
                            end
                        end
                    end
                    else if (first && (message_size == '0))
                    begin
                        adm_next    = 1'b0;
                        pkg_go_next = 1'b0;
                        state_next  = ST_STAT;
                    end
                    else
                    begin
                        left_next = left_dec;
                        acc_next  = acc_eff;
                        if (wr_en)
                        begin
                            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0
                                          : wr_ptr_reg + PTR_W'(1);
                        end
                        count_next = count_w;
                        if (left_dec == '0)
                        begin
                            acc_next = 1'b0;
                            if (acc_eff && idle_reg && (count_w != '0))
                            begin
                                idle_next = 1'b0;
                                pkg_start = 1'b1;
                            end
                        end
                        adm_next    = fits;
                        pkg_go_next = pkg_start;
                        if (first)
                        begin
                            state_next = ST_STAT;
                        end
                        else if (pkg_start)
                        begin
                            state_next = ST_RD;
                        end
                    end
                    if (pkg_start)
                    begin
                        count_next    = pkg_src - CNT_W'(take);
                        pkg_n_next    = take;
                        pkg_left_next = take;
                    end
                end
            end
            ST_STAT:
            begin
                if (out_fire)
                begin
                    state_next = pkg_go_reg ? ST_RD : ST_IDLE;
                end
            end
            ST_RD:
            begin
                rd_ptr_next   = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
                pkg_left_next = pkg_left_reg - PKG_W'(1);
                state_next    = ST_BYTE;
            end
            ST_BYTE:
            begin
                if (out_fire)
                begin
                    state_next = (pkg_left_reg == '0) ? ST_IDLE : ST_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            count_reg    <= '0;
            idle_reg     <= 1'b1;
            left_reg     <= '0;
            acc_reg      <= 1'b0;
            pkg_left_reg <= '0;
            pkg_n_reg    <= '0;
            adm_reg      <= 1'b0;
            pkg_go_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_ptr_reg   <= rd_ptr_next;
            wr_ptr_reg   <= wr_ptr_next;
            count_reg    <= count_next;
            idle_reg     <= idle_next;
            left_reg     <= left_next;
            acc_reg      <= acc_next;
            pkg_left_reg <= pkg_left_next;
            pkg_n_reg    <= pkg_n_next;
            adm_reg      <= adm_next;
            pkg_go_reg   <= pkg_go_next;
        end
    end

    ctrb_ram #(
        .WIDTH (ctrb_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_ptr_reg),
        .wdata (data_byte),
        .re    (rd_en),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    assign in_ready        = (state_reg == ST_IDLE);
    assign out_valid       = (state_reg == ST_STAT) || (state_reg == ST_BYTE);
    assign result_kind     = (state_reg == ST_BYTE) ? ctrb_pkg::KIND_PKG
                                                    : ctrb_pkg::KIND_STATUS;
    assign admitted        = (state_reg == ST_STAT) && adm_reg;
    assign out_byte        = (state_reg == ST_BYTE) ? ram_rdata : '0;
    assign last_in_package = (state_reg == ST_BYTE) && (pkg_left_reg == '0);
    assign package_length  = (state_reg == ST_BYTE) ? ctrb_pkg::PLEN_W'(pkg_n_reg) : '0;

endmodule

`default_nettype wire

@@ rtl/ctrb_checker.sv @@
// Port-level checks of the chunked transmit ring buffer, bound to the top level.
`default_nettype none

module ctrb_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic                        result_kind,
    input wire logic [ctrb_pkg::DATA_W-1:0] out_byte,
    input wire logic                        last_in_package
);

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result is pending");

    a_status_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid) && (result_kind == ctrb_pkg::KIND_STATUS))
        |-> $past(in_valid && in_ready))
        else $error("status result without an accepted item");

    a_package_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && (result_kind == ctrb_pkg::KIND_PKG)
         && !last_in_package) |=> !in_ready)
        else $error("package cut short");

    a_stalled_byte_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_byte)))
        else $error("stalled result changed");

endmodule

bind chunked_transmit_ring_buffer ctrb_checker u_ctrb_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .result_kind     (result_kind),
    .out_byte        (out_byte),
    .last_in_package (last_in_package)
);

`default_nettype wire

@@ tb/chunked_transmit_ring_buffer_tb.sv @@
// Testbench for the chunked transmit ring buffer: random traffic checked against a predictor.
`timescale 1ns / 100ps

module chunked_transmit_ring_buffer_tb;

    localparam int DATA_W     = ctrb_pkg::DATA_W;
    localparam int SIZE_W     = ctrb_pkg::SIZE_W;
    localparam int PLEN_W     = ctrb_pkg::PLEN_W;
    localparam int BUF_DEPTH  = ctrb_pkg::CAPACITY_DEF;
    localparam int PKG_BYTES  = ctrb_pkg::PACKAGE_BYTES_DEF;
    localparam int RAND_ITEMS = 16;
    localparam int TAIL_WAIT  = 40;

    typedef struct {
        logic              act;
        logic [DATA_W-1:0] data;
        logic [SIZE_W-1:0] size;
    } tx_item_t;

    typedef struct {
        logic              kind;
        logic              adm;
        logic [DATA_W-1:0] data;
        logic              last;
        logic [PLEN_W-1:0] plen;
    } tx_result_t;

    logic              clk             = 1'b0;
    logic              rst_n           = 1'b0;
    logic              in_valid        = 1'b0;
    logic              in_ready;
    logic              action          = ctrb_pkg::ACT_BYTE;
    logic [DATA_W-1:0] data_byte       = '0;
    logic [SIZE_W-1:0] message_size    = '0;
    logic              out_valid;
    logic              out_ready       = 1'b0;
    logic              result_kind;
    logic              admitted;
    logic [DATA_W-1:0] out_byte;
    logic              last_in_package;
    logic [PLEN_W-1:0] package_length;

    tx_item_t   pending_items[$];
    tx_result_t expected_results[$];
    int         queued_items   = 0;
    int         mismatch_count = 0;

    logic in_taken   = 1'b0;
    logic out_taken  = 1'b0;
    int   send_wait  = 0;
    int   recv_wait  = 0;
    bit   send_steady = 1'b0;
    bit   recv_steady = 1'b0;

    // Predicted buffer state
    logic [DATA_W-1:0] shadow_store [BUF_DEPTH];
    logic [6:0]        head_ptr     = '0;
    logic [6:0]        tail_ptr     = '0;
    logic [7:0]        fill_level   = '0;
    logic              link_idle_m  = 1'b1;
    logic [7:0]        msg_left     = '0;
    logic              msg_admitted = 1'b0;

    chunked_transmit_ring_buffer i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .data_byte       (data_byte),
        .message_size    (message_size),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_kind     (result_kind),
        .admitted        (admitted),
        .out_byte        (out_byte),
        .last_in_package (last_in_package),
        .package_length  (package_length)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [6:0] next_slot(input logic [6:0] p);
        return (p == BUF_DEPTH - 1) ? 7'd0 : p + 7'd1;
    endfunction

    function automatic void push_status(input logic ok);
        tx_result_t r;
        r.kind = ctrb_pkg::KIND_STATUS;
        r.adm  = ok;
        r.data = '0;
        r.last = 1'b0;
        r.plen = '0;
        expected_results.push_back(r);
    endfunction

    function automatic void emit_package();
        int         n;
        tx_result_t r;
        n = (fill_level > PKG_BYTES) ? PKG_BYTES : fill_level;
        for (int i = 0; i < n; i++)
        begin
            r.kind = ctrb_pkg::KIND_PKG;
            r.adm  = 1'b0;
            r.data = shadow_store[head_ptr];
            r.last = (i == n - 1);
            r.plen = n[PLEN_W-1:0];
            expected_results.push_back(r);
            head_ptr = next_slot(head_ptr);
        end
        fill_level = fill_level - n[7:0];
    endfunction

    function automatic void buffer_item(input logic act, input logic [DATA_W-1:0] data,
                                        input logic [SIZE_W-1:0] size);
        if (act == ctrb_pkg::ACT_DONE)
        begin
            if (link_idle_m)
                return;
            if (fill_level == 0)
            begin
                link_idle_m = 1'b1;
                return;
            end
            emit_package();
            return;
        end
        if (msg_left == 0)
        begin
            if (size == 0)
            begin
                push_status(1'b0);
                return;
            end
            msg_admitted = (int'(fill_level) + int'(size) <= BUF_DEPTH);
            msg_left     = size;
            push_status(msg_admitted);
        end
        if (msg_admitted && fill_level < BUF_DEPTH)
        begin
            shadow_store[tail_ptr] = data;
            tail_ptr   = next_slot(tail_ptr);
            fill_level = fill_level + 8'd1;
        end
        msg_left = msg_left - 8'd1;
        if (msg_left == 0)
        begin
            if (msg_admitted && link_idle_m && fill_level > 0)
            begin
                link_idle_m = 1'b0;
                emit_package();
            end
            msg_admitted = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("tb: mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic int draw_gap(input bit steady);
        return steady ? 0 : $urandom_range(0, 5);
    endfunction

    // Drive items
    always @(negedge clk)
    begin : drive_items
        tx_item_t nxt;
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (send_wait != 0)
                begin
                    in_valid  <= 1'b0;
                    send_wait <= send_wait - 1;
                end
                else if (pending_items.size() != 0)
                begin
                    nxt = pending_items.pop_front();
                    in_valid     <= 1'b1;
                    action       <= nxt.act;
                    data_byte    <= nxt.data;
                    message_size <= nxt.size;
                    if ($urandom_range(0, 23) == 0)
                        send_steady = !send_steady;
                    send_wait <= draw_gap(send_steady);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Stall results
    always @(negedge clk)
    begin : drive_ready
        int w;
        if (rst_n)
        begin
            w = recv_wait;
            if (out_taken)
            begin
                if ($urandom_range(0, 23) == 0)
                    recv_steady = !recv_steady;
                w = draw_gap(recv_steady);
            end
            else if (w > 0)
            begin
                w = w - 1;
            end
            recv_wait <= w;
            out_ready <= (w == 0);
        end
    end

    // Predict accepted items, check accepted results
    always @(posedge clk)
    begin : watch_channels
        tx_result_t want;
        in_taken  <= in_valid && in_ready;
        out_taken <= out_valid && out_ready;
        if (in_valid && in_ready)
            buffer_item(action, data_byte, message_size);
        if (out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("result with nothing expected");
            end
            else
            begin
                want = expected_results.pop_front();
                if (result_kind !== want.kind)
                    report_mismatch($sformatf("result_kind got %0d want %0d",
                                              result_kind, want.kind));
                if (admitted !== want.adm)
                    report_mismatch($sformatf("admitted got %0d want %0d",
                                              admitted, want.adm));
                if (out_byte !== want.data)
                    report_mismatch($sformatf("out_byte got %0h want %0h",
                                              out_byte, want.data));
                if (last_in_package !== want.last)
                    report_mismatch($sformatf("last_in_package got %0d want %0d",
                                              last_in_package, want.last));
                if (package_length !== want.plen)
                    report_mismatch($sformatf("package_length got %0d want %0d",
                                              package_length, want.plen));
            end
        end
    end

    task automatic push_item(input logic act, input logic [DATA_W-1:0] data,
                             input logic [SIZE_W-1:0] size);
        tx_item_t it;
        it.act  = act;
        it.data = data;
        it.size = size;
        pending_items.push_back(it);
        queued_items++;
    endtask

    task automatic push_link_done();
        push_item(ctrb_pkg::ACT_DONE, DATA_W'($urandom_range(0, 255)),
                  SIZE_W'($urandom_range(0, 255)));
    endtask

    // A zero size still sends one byte; later bytes carry random size fields
    task automatic push_message(input int size, input logic [DATA_W-1:0] first_data,
                                input bit with_dones);
        int cnt;
        cnt = (size == 0) ? 1 : size;
        push_item(ctrb_pkg::ACT_BYTE, first_data, SIZE_W'(size));
        for (int k = 1; k < cnt; k++)
        begin
            if (with_dones && $urandom_range(0, 15) == 0)
                push_link_done();
            push_item(ctrb_pkg::ACT_BYTE, DATA_W'($urandom_range(0, 255)),
                      SIZE_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        int  rand_stop;
        int  msg_count;
        int  pick;
        int  size;
        bit  drain_heavy;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        push_link_done();
        push_message(0, 8'hFF, 1'b0);
        push_message(1, 8'h00, 1'b0);
        push_link_done();
        push_message(9, 8'hFF, 1'b0);
        push_link_done();
        push_item(ctrb_pkg::ACT_BYTE, 8'h5A, 8'd4);
        push_link_done();
        push_link_done();
        push_item(ctrb_pkg::ACT_BYTE, 8'hA5, 8'h00);
        push_item(ctrb_pkg::ACT_BYTE, 8'h3C, 8'hFF);
        push_item(ctrb_pkg::ACT_BYTE, 8'hC3, 8'h81);
        push_link_done();
        wait_drained();

        // Fill to exact capacity from an empty, idle buffer
        while (fill_level != 0 || !link_idle_m)
        begin
            push_link_done();
            wait_drained();
        end
        push_message(BUF_DEPTH, 8'h81, 1'b0);
        push_message(PKG_BYTES + 1, 8'h7E, 1'b0);

        rand_stop   = queued_items + RAND_ITEMS;
        msg_count   = 0;
        drain_heavy = 1'b1;
        while (queued_items < rand_stop)
        begin
            if (msg_count % 10 == 0)
                drain_heavy = $urandom_range(0, 1);
            pick = $urandom_range(0, 99);
            if (pick < 4)
                size = 0;
            else if (pick < 88)
                size = $urandom_range(1, 12);
            else
                size = $urandom_range(13, 48);
            push_message(size, DATA_W'($urandom_range(0, 255)), 1'b1);
            msg_count++;
            if (drain_heavy)
                repeat ($urandom_range(0, 2)) push_link_done();
            else if ($urandom_range(0, 5) == 0)
                push_link_done();
            if (msg_count == 12)
                wait_drained();
        end

        wait_drained();
        repeat (TAIL_WAIT) @(negedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ chunked_transmit_ring_buffer.f @@
rtl/ctrb_pkg.sv
rtl/ctrb_ram.sv
rtl/chunked_transmit_ring_buffer.sv
rtl/ctrb_checker.sv
tb/chunked_transmit_ring_buffer_tb.sv
